/* rtl/mmr_pkg.sv */
// Shared types and constants for the row-wise integer matrix multiply unit.
// No dependencies; used by mmr_front, mmr_queue, mmr_back and the top level.
`default_nettype none

package mmr_pkg;

  localparam int ELEM_W     = 32;
  localparam int ROW_W      = 8;
  localparam int IDX_W      = 4;
  localparam int COL_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int LEN_REG_W  = 5;
  localparam int COLS_REG_W = 3;

  localparam logic [LEN_REG_W-1:0]  LEN_RESET  = 5'd16;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic {
    OP_LOAD_B   = 1'b0,
    OP_STREAM_A = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER_LENGTH   = 1'b0,
    CFG_OUTPUT_COLUMNS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ACCUM  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ROW_W-1:0]   row;
    logic [IDX_W-1:0]   idx;
    logic [COL_W-1:0]   col;
    logic [ELEM_W-1:0]  elem;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/mmr_front.sv */
// Front end: configuration registers, input acceptance and item classification.
// Depends on mmr_pkg; feeds mmr_queue.
`default_nettype none

module mmr_front #(
  parameter int INNER_MAX       = 16,
  parameter int OUT_COLUMNS_MAX = 4,
  parameter int NCOLS_W         = 3
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_wr_en_i,
  input  wire [mmr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [mmr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                              in_valid_i,
  input  wire                              in_stall_i,
  input  wire                              opcode_i,
  input  wire [mmr_pkg::ROW_W-1:0]         row_tag_i,
  input  wire [mmr_pkg::IDX_W-1:0]         inner_index_i,
  input  wire [mmr_pkg::COL_W-1:0]         b_column_i,
  input  wire [mmr_pkg::ELEM_W-1:0]        element_i,
  output logic                             push_o,
  output mmr_pkg::cmd_t                    cmd_o,
  output logic [NCOLS_W-1:0]               ncols_o
);

  localparam int LEN_W = $clog2(INNER_MAX + 1);

  logic [mmr_pkg::LEN_REG_W-1:0]  inner_len_q;
  logic [mmr_pkg::COLS_REG_W-1:0] out_cols_q;
  logic [LEN_W-1:0]               len_eff;
  logic                           keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_len_q <= mmr_pkg::LEN_RESET;
      out_cols_q  <= mmr_pkg::COLS_RESET;
    end else if (cfg_wr_en_i) begin
      case (mmr_pkg::cfg_idx_e'(cfg_idx_i))
        mmr_pkg::CFG_INNER_LENGTH:   inner_len_q <= cfg_data_i[mmr_pkg::LEN_REG_W-1:0];
        mmr_pkg::CFG_OUTPUT_COLUMNS: out_cols_q  <= cfg_data_i[mmr_pkg::COLS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate both registers to their legal ranges.
  always_comb begin
    if (inner_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(inner_len_q) > 32'(INNER_MAX)) begin
      len_eff = LEN_W'(INNER_MAX);
    end else begin
      len_eff = LEN_W'(inner_len_q);
    end
    if (out_cols_q == '0) begin
      ncols_o = NCOLS_W'(1);
    end else if (32'(out_cols_q) > 32'(OUT_COLUMNS_MAX)) begin
      ncols_o = NCOLS_W'(OUT_COLUMNS_MAX);
    end else begin
      ncols_o = NCOLS_W'(out_cols_q);
    end
  end

  // Classify: drop out-of-range loads and elements beyond the row.
  always_comb begin
    cmd_o.row  = row_tag_i;
    cmd_o.idx  = inner_index_i;
    cmd_o.col  = b_column_i;
    cmd_o.elem = element_i;
    cmd_o.kind = mmr_pkg::KIND_LOAD;
    keep       = 1'b0;
    case (mmr_pkg::opcode_e'(opcode_i))
      mmr_pkg::OP_LOAD_B: begin
        keep = (32'(inner_index_i) < 32'(INNER_MAX)) &&
               (32'(b_column_i) < 32'(OUT_COLUMNS_MAX));
      end
      mmr_pkg::OP_STREAM_A: begin
        keep = 32'(inner_index_i) < 32'(len_eff);
        cmd_o.kind = (32'(inner_index_i) == 32'(len_eff) - 32'd1) ?
                     mmr_pkg::KIND_FINISH : mmr_pkg::KIND_ACCUM;
      end
      default: ;
    endcase
  end

  assign push_o = in_valid_i && !in_stall_i && keep;

endmodule

`default_nettype wire

/* rtl/mmr_queue.sv */
// Short command queue between the front end and the compute back end.
// Depends on mmr_pkg for the command type and depth constants.
`default_nettype none

module mmr_queue #(
  parameter int NCOLS_W = 3
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire mmr_pkg::cmd_t   cmd_i,
  input  wire [NCOLS_W-1:0]    ncols_i,
  input  wire                  pop_i,
  output logic                 valid_o,
  output logic                 full_o,
  output mmr_pkg::cmd_t        cmd_o,
  output logic [NCOLS_W-1:0]   ncols_o
);

  mmr_pkg::cmd_t                 cmd_q   [mmr_pkg::QUEUE_DEPTH];
  logic [NCOLS_W-1:0]            ncols_q [mmr_pkg::QUEUE_DEPTH];
  logic [mmr_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [mmr_pkg::QCNT_W-1:0]    count_q, count_d;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == mmr_pkg::QCNT_W'(mmr_pkg::QUEUE_DEPTH);
  assign cmd_o   = cmd_q[rd_ptr_q];
  assign ncols_o = ncols_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) begin
      count_d = count_q + mmr_pkg::QCNT_W'(1);
    end else if (!push_i && pop_i && valid_o) begin
      count_d = count_q - mmr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + mmr_pkg::QPTR_W'(1);
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_q + mmr_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q]   <= cmd_i;
      ncols_q[wr_ptr_q] <= ncols_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/mmr_back.sv */
// Back end: B store per column lane, multiply stage, column accumulators and
// the result buffer that bursts one row out. Depends on mmr_pkg.
`default_nettype none

module mmr_back #(
  parameter int INNER_MAX       = 16,
  parameter int OUT_COLUMNS_MAX = 4,
  parameter int NCOLS_W         = 3
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                q_valid_i,
  input  wire mmr_pkg::cmd_t                 q_cmd_i,
  input  wire [NCOLS_W-1:0]                  q_ncols_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [mmr_pkg::ROW_W-1:0]          out_row_o,
  output logic [mmr_pkg::COL_W-1:0]          out_column_o,
  output logic [mmr_pkg::ELEM_W-1:0]         product_value_o,
  output logic                               row_done_o
);

  localparam int AW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int EW = mmr_pkg::ELEM_W;

  logic          advance, res_free, out_take, out_last;
  logic          is_load, is_stream, is_fin, b_wr, b_rd;
  logic [AW-1:0] addr;

  // Stage 1: B row read
  logic                       s1_valid_q, s1_fin_q;
  logic [mmr_pkg::ROW_W-1:0]  s1_row_q;
  logic [EW-1:0]              s1_elem_q;
  logic [NCOLS_W-1:0]         s1_ncols_q;
  logic [EW-1:0]              b_row [OUT_COLUMNS_MAX];

  // Stage 2: products
  logic                       s2_valid_q, s2_fin_q;
  logic [mmr_pkg::ROW_W-1:0]  s2_row_q;
  logic [NCOLS_W-1:0]         s2_ncols_q;
  logic [EW-1:0]              prod_q [OUT_COLUMNS_MAX];
  logic [EW-1:0]              prod_d [OUT_COLUMNS_MAX];

  // Accumulators and result buffer
  logic [EW-1:0]              acc_q  [OUT_COLUMNS_MAX];
  logic [EW-1:0]              sum    [OUT_COLUMNS_MAX];
  logic [EW-1:0]              res_q  [OUT_COLUMNS_MAX];
  logic                       res_busy_q;
  logic [mmr_pkg::ROW_W-1:0]  res_row_q;
  logic [NCOLS_W-1:0]         res_ncols_q, res_cnt_q;
  logic                       fin_take;

  always_comb begin
    is_load = 1'b0;
    is_fin  = 1'b0;
    case (q_cmd_i.kind)
      mmr_pkg::KIND_LOAD:   is_load = 1'b1;
      mmr_pkg::KIND_FINISH: is_fin  = 1'b1;
      default: ;
    endcase
    is_stream = !is_load;
  end

  assign out_take = res_busy_q && !out_stall_i;
  assign out_last = out_take && row_done_o;
  assign res_free = !res_busy_q || out_last;
  // Hold the whole pipe only when a row ends and the buffer is still draining.
  assign advance  = !(s2_valid_q && s2_fin_q) || res_free;
  assign q_pop_o  = q_valid_i && advance;
  assign b_wr     = q_pop_o && is_load;
  assign b_rd     = q_pop_o && is_stream;
  assign addr     = AW'(q_cmd_i.idx);
  assign fin_take = advance && s2_valid_q && s2_fin_q;

  for (genvar g = 0; g < OUT_COLUMNS_MAX; g++) begin : g_lane
    logic [EW-1:0] b_mem [INNER_MAX];
    logic [EW-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (b_wr && (32'(q_cmd_i.col) == 32'(g))) begin
        b_mem[addr] <= q_cmd_i.elem;
      end
      if (b_rd) begin
        rd_q <= b_mem[addr];
      end
    end

    assign b_row[g] = rd_q;
  end

  // Lanes beyond the active column count contribute nothing.
  always_comb begin
    for (int i = 0; i < OUT_COLUMNS_MAX; i++) begin
      prod_d[i] = (32'(i) < 32'(s1_ncols_q)) ? EW'(s1_elem_q * b_row[i]) : '0;
      sum[i]    = acc_q[i] + prod_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      res_busy_q <= 1'b0;
      res_cnt_q  <= '0;
      for (int i = 0; i < OUT_COLUMNS_MAX; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      if (advance) begin
        s1_valid_q <= b_rd;
        s2_valid_q <= s1_valid_q;
        if (s2_valid_q) begin
          for (int i = 0; i < OUT_COLUMNS_MAX; i++) begin
            acc_q[i] <= s2_fin_q ? '0 : sum[i];
          end
        end
      end
      if (fin_take) begin
        res_busy_q <= 1'b1;
        res_cnt_q  <= '0;
      end else if (out_last) begin
        res_busy_q <= 1'b0;
      end else if (out_take) begin
        res_cnt_q <= res_cnt_q + NCOLS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_fin_q   <= is_fin;
      s1_row_q   <= q_cmd_i.row;
      s1_elem_q  <= q_cmd_i.elem;
      s1_ncols_q <= q_ncols_i;
      s2_fin_q   <= s1_fin_q;
      s2_row_q   <= s1_row_q;
      s2_ncols_q <= s1_ncols_q;
      for (int i = 0; i < OUT_COLUMNS_MAX; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
    // Load the finished row, else shift one column out per beat.
    if (fin_take) begin
      res_row_q   <= s2_row_q;
      res_ncols_q <= s2_ncols_q;
      for (int i = 0; i < OUT_COLUMNS_MAX; i++) begin
        res_q[i] <= sum[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < OUT_COLUMNS_MAX - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  assign out_valid_o     = res_busy_q;
  assign out_row_o       = res_row_q;
  assign out_column_o    = mmr_pkg::COL_W'(res_cnt_q);
  assign product_value_o = res_q[0];
  assign row_done_o      = res_cnt_q == (res_ncols_q - NCOLS_W'(1));

`ifndef SYNTH
  a_first_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take |=> (res_busy_q && res_cnt_q == '0))
    else $error("result burst does not start at column zero");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_busy_q |-> (32'(res_cnt_q) < 32'(res_ncols_q)))
    else $error("result column counter past active column count");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take |=> (acc_q[0] == '0))
    else $error("accumulator not cleared after row end");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_busy_q && !out_last) |-> !fin_take)
    else $error("result buffer reloaded while still draining");
`endif

endmodule

`default_nettype wire

/* rtl/int32_matrix_multiply_rows_unit.sv */
// Top level of the row-wise int32 matrix multiply unit.
// Depends on mmr_pkg, mmr_front, mmr_queue and mmr_back.
//
//   Channel  Direction  Handshake                 Payload
//   cfg      in         cfg_wr_en_i               cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o   opcode, row_tag, inner_index,
//                                                 b_column, element
//   out      out        out_valid_o / out_stall_i out_row, out_column,
//                                                 product_value, row_done
//
// One input item per cycle while in_stall_o is low; the back end pipeline
// (B read, multiply, accumulate) carries a finished row into the output register.
// A row's results leave one per cycle while out_stall_i is low; a row end
// stalls the pipe only while the previous row is still bursting out.
// Reset clears control state and the accumulators; the B store is not cleared.
// The input stalls only when the four-entry command queue is full.
`default_nettype none

module int32_matrix_multiply_rows_unit #(
  parameter int INNER_MAX       = 16,
  parameter int OUT_COLUMNS_MAX = 4
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_wr_en_i,
  input  wire [mmr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [mmr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              opcode_i,
  input  wire [mmr_pkg::ROW_W-1:0]         row_tag_i,
  input  wire [mmr_pkg::IDX_W-1:0]         inner_index_i,
  input  wire [mmr_pkg::COL_W-1:0]         b_column_i,
  input  wire signed [mmr_pkg::ELEM_W-1:0] element_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [mmr_pkg::ROW_W-1:0]        out_row_o,
  output logic [mmr_pkg::COL_W-1:0]        out_column_o,
  output logic signed [mmr_pkg::ELEM_W-1:0] product_value_o,
  output logic                             row_done_o
);

  localparam int NCOLS_W = $clog2(OUT_COLUMNS_MAX + 1);

  logic                        push, pop, q_valid, q_full;
  mmr_pkg::cmd_t               f_cmd, q_cmd;
  logic [NCOLS_W-1:0]          f_ncols, q_ncols;
  logic [mmr_pkg::ELEM_W-1:0]  result;

  assign in_stall_o      = q_full;
  assign product_value_o = $signed(result);

  mmr_front #(
    .INNER_MAX       (INNER_MAX),
    .OUT_COLUMNS_MAX (OUT_COLUMNS_MAX),
    .NCOLS_W         (NCOLS_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (q_full),
    .opcode_i      (opcode_i),
    .row_tag_i     (row_tag_i),
    .inner_index_i (inner_index_i),
    .b_column_i    (b_column_i),
    .element_i     ($unsigned(element_i)),
    .push_o        (push),
    .cmd_o         (f_cmd),
    .ncols_o       (f_ncols)
  );

  mmr_queue #(
    .NCOLS_W (NCOLS_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .ncols_i (f_ncols),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .cmd_o   (q_cmd),
    .ncols_o (q_ncols)
  );

  mmr_back #(
    .INNER_MAX       (INNER_MAX),
    .OUT_COLUMNS_MAX (OUT_COLUMNS_MAX),
    .NCOLS_W         (NCOLS_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_ncols_i       (q_ncols),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_column_o    (out_column_o),
    .product_value_o (result),
    .row_done_o      (row_done_o)
  );

endmodule

`default_nettype wire

/* tb/tb_int32_matrix_multiply_rows_unit.sv */
`timescale 1ns / 100ps
// Testbench for int32_matrix_multiply_rows_unit: fills the B store, streams rows of A under
// several register settings and checks every result beat against a local predictor.
// Depends on mmr_pkg and the unit's RTL only.
module tb_int32_matrix_multiply_rows_unit;

  localparam int INNER_MAX      = 16;
  localparam int NUM_COLS       = 4;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 30;
  localparam int NUM_PHASES     = 10;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_wr_en_i = 1'b0;
  logic [mmr_pkg::CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [mmr_pkg::CFG_DATA_W-1:0]    cfg_data_i  = '0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  logic                              opcode_i      = 1'b0;
  logic [mmr_pkg::ROW_W-1:0]         row_tag_i     = '0;
  logic [mmr_pkg::IDX_W-1:0]         inner_index_i = '0;
  logic [mmr_pkg::COL_W-1:0]         b_column_i    = '0;
  logic signed [mmr_pkg::ELEM_W-1:0] element_i     = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [mmr_pkg::ROW_W-1:0]         out_row_o;
  logic [mmr_pkg::COL_W-1:0]         out_column_o;
  logic signed [mmr_pkg::ELEM_W-1:0] product_value_o;
  logic                              row_done_o;

  typedef struct {
    logic [mmr_pkg::ROW_W-1:0]  row;
    logic [mmr_pkg::COL_W-1:0]  col;
    logic [mmr_pkg::ELEM_W-1:0] value;
    logic                       last;
  } c_beat_t;

  c_beat_t c_expected_q[$];

  // Predictor state
  logic [mmr_pkg::ELEM_W-1:0]     b_store [INNER_MAX*NUM_COLS];
  logic [mmr_pkg::ELEM_W-1:0]     col_sums [NUM_COLS];
  logic [mmr_pkg::LEN_REG_W-1:0]  len_reg  = mmr_pkg::LEN_RESET;
  logic [mmr_pkg::COLS_REG_W-1:0] cols_reg = mmr_pkg::COLS_RESET;

  bit          gaps_on  = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_count = 0;
  int unsigned items_accepted = 0;
  int unsigned useful_items = 0;
  int unsigned beats_checked = 0;
  int unsigned rows_done = 0;
  int unsigned settings_applied = 0;

  always #2 clk_i = ~clk_i;

  int32_matrix_multiply_rows_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .row_tag_i      (row_tag_i),
    .inner_index_i  (inner_index_i),
    .b_column_i     (b_column_i),
    .element_i      (element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_o      (out_row_o),
    .out_column_o   (out_column_o),
    .product_value_o(product_value_o),
    .row_done_o     (row_done_o)
  );

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > INNER_MAX) return INNER_MAX;
    return 32'(len_reg);
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > NUM_COLS) return NUM_COLS;
    return 32'(cols_reg);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [mmr_pkg::ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Row-wise multiply-accumulate: update the store or sums, queue a row of C when it closes
  task automatic accumulate_row_item(input mmr_pkg::opcode_e op,
                                     input logic [mmr_pkg::ROW_W-1:0] row,
                                     input logic [mmr_pkg::IDX_W-1:0] k,
                                     input logic [mmr_pkg::COL_W-1:0] col,
                                     input logic [mmr_pkg::ELEM_W-1:0] value);
    int unsigned len;
    int unsigned ncols;
    logic [mmr_pkg::ELEM_W-1:0] prod;
    c_beat_t beat;
    len   = eff_len();
    ncols = eff_cols();
    if (op == mmr_pkg::OP_LOAD_B) begin
      b_store[k * NUM_COLS + col] = value;
      return;
    end
    if (k >= len) return;
    for (int j = 0; j < ncols; j++) begin
      prod        = value * b_store[k * NUM_COLS + j];
      col_sums[j] = col_sums[j] + prod;
    end
    if (k != len - 1) return;
    for (int j = 0; j < ncols; j++) begin
      beat.row   = row;
      beat.col   = mmr_pkg::COL_W'(j);
      beat.value = col_sums[j];
      beat.last  = (j == ncols - 1);
      c_expected_q.push_back(beat);
    end
    for (int j = 0; j < NUM_COLS; j++) col_sums[j] = '0;
    rows_done++;
  endtask

  task automatic send_item(input mmr_pkg::opcode_e op, input logic [mmr_pkg::ROW_W-1:0] row,
                           input logic [mmr_pkg::IDX_W-1:0] k,
                           input logic [mmr_pkg::COL_W-1:0] col,
                           input logic [mmr_pkg::ELEM_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    row_tag_i     <= row;
    inner_index_i <= k;
    b_column_i    <= col;
    element_i     <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_accepted++;
    if (!(op == mmr_pkg::OP_STREAM_A && k >= eff_len())) useful_items++;
    accumulate_row_item(op, row, k, col, value);
  endtask

  task automatic send_row(input logic [mmr_pkg::ROW_W-1:0] tag, input int unsigned last_k);
    for (int unsigned k = 0; k <= last_k; k++) begin
      send_item(mmr_pkg::OP_STREAM_A, tag, mmr_pkg::IDX_W'(k), mmr_pkg::COL_W'($urandom),
                pick_elem());
    end
  endtask

  // Drop valid, drain every expected beat, then let the pipe empty of silent items
  task automatic settle();
    in_valid_i <= 1'b0;
    while (c_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [mmr_pkg::CFG_DATA_W-1:0] len_val,
                                input logic [mmr_pkg::CFG_DATA_W-1:0] cols_val);
    cfg_wr_en_i <= 1'b1;
    cfg_idx_i   <= mmr_pkg::CFG_INNER_LENGTH;
    cfg_data_i  <= len_val;
    @(posedge clk_i);
    len_reg = len_val[mmr_pkg::LEN_REG_W-1:0];
    cfg_idx_i  <= mmr_pkg::CFG_OUTPUT_COLUMNS;
    cfg_data_i <= cols_val;
    @(posedge clk_i);
    cols_reg = cols_val[mmr_pkg::COLS_REG_W-1:0];
    cfg_wr_en_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic check_field(input string name, input logic [mmr_pkg::ELEM_W-1:0] want,
                             input logic [mmr_pkg::ELEM_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    c_beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (c_expected_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, got row %0h col %0h value %0h last %0b",
                 $time, out_row_o, out_column_o, product_value_o, row_done_o);
      end else begin
        want = c_expected_q.pop_front();
        beats_checked++;
        check_field("out_row", mmr_pkg::ELEM_W'(want.row), mmr_pkg::ELEM_W'(out_row_o));
        check_field("out_column", mmr_pkg::ELEM_W'(want.col),
                    mmr_pkg::ELEM_W'(out_column_o));
        check_field("product_value", want.value, product_value_o);
        check_field("row_done", mmr_pkg::ELEM_W'(want.last), mmr_pkg::ELEM_W'(row_done_o));
      end
    end
  end

  // Receiver: random stalls, or one long hold-off on request
  always @(posedge clk_i) begin : out_stall_gen
    logic stall_now;
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && gaps_on && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
    end
    stall_now = (stall_left != 0);
    if (stall_left != 0) stall_left--;
    out_stall_i <= stall_now;
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_int32_matrix_multiply_rows_unit: done, errors");
      $finish;
    end
  end

  task automatic test_fill_store();
    gaps_on = 1'b1;
    for (int k = 0; k < INNER_MAX; k++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        send_item(mmr_pkg::OP_LOAD_B, mmr_pkg::ROW_W'($urandom), mmr_pkg::IDX_W'(k),
                  mmr_pkg::COL_W'(c), pick_elem());
      end
    end
  endtask

  task automatic test_directed();
    settle();
    apply_settings(5'd2, 5'd4);
    // B rows 0 and 1 hold the extreme values
    send_item(mmr_pkg::OP_LOAD_B, 8'h00, 4'd0, 2'd0, 32'h7fff_ffff);
    send_item(mmr_pkg::OP_LOAD_B, 8'h00, 4'd0, 2'd1, 32'h8000_0000);
    send_item(mmr_pkg::OP_LOAD_B, 8'h00, 4'd0, 2'd2, 32'hffff_ffff);
    send_item(mmr_pkg::OP_LOAD_B, 8'h00, 4'd0, 2'd3, 32'h0000_0000);
    send_item(mmr_pkg::OP_LOAD_B, 8'hff, 4'd1, 2'd0, 32'h0000_0001);
    send_item(mmr_pkg::OP_LOAD_B, 8'hff, 4'd1, 2'd1, 32'hffff_ffff);
    send_item(mmr_pkg::OP_LOAD_B, 8'hff, 4'd1, 2'd2, 32'h8000_0000);
    send_item(mmr_pkg::OP_LOAD_B, 8'hff, 4'd1, 2'd3, 32'h7fff_ffff);
    // full rows at both ends of the row tag range
    send_item(mmr_pkg::OP_STREAM_A, 8'h00, 4'd0, 2'd0, 32'h8000_0000);
    send_item(mmr_pkg::OP_STREAM_A, 8'h00, 4'd1, 2'd3, 32'h7fff_ffff);
    send_item(mmr_pkg::OP_STREAM_A, 8'hff, 4'd0, 2'd2, 32'hffff_ffff);
    send_item(mmr_pkg::OP_STREAM_A, 8'hff, 4'd1, 2'd1, 32'h0000_0001);
    // index past the row length: dropped
    send_item(mmr_pkg::OP_STREAM_A, 8'h11, 4'd15, 2'd0, 32'h1234_5678);
    // last index alone closes a row
    send_item(mmr_pkg::OP_STREAM_A, 8'h22, 4'd1, 2'd0, 32'h7fff_ffff);
    // register change mid-row keeps the partial sums
    send_item(mmr_pkg::OP_STREAM_A, 8'h33, 4'd0, 2'd0, 32'hdead_beef);
    settle();
    apply_settings(5'd3, 5'd1);
    send_item(mmr_pkg::OP_STREAM_A, 8'h33, 4'd1, 2'd0, 32'hffff_fffb);
    send_item(mmr_pkg::OP_STREAM_A, 8'h33, 4'd2, 2'd0, 32'h0000_0007);
  endtask

  task automatic test_backpressure();
    settle();
    apply_settings(5'd1, 5'd4);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    // every item closes a row of four beats while the receiver holds off
    repeat (30) send_item(mmr_pkg::OP_STREAM_A, mmr_pkg::ROW_W'($urandom), 4'd0,
                          mmr_pkg::COL_W'($urandom), pick_elem());
    settle();
  endtask

  task automatic test_random_phases();
    logic [mmr_pkg::CFG_DATA_W-1:0] len_set [NUM_PHASES];
    logic [mmr_pkg::CFG_DATA_W-1:0] cols_set [NUM_PHASES];
    int unsigned target;
    int unsigned len;
    int unsigned pick;
    logic [mmr_pkg::ROW_W-1:0] tag;
    len_set  = '{5'd16, 5'd1, 5'd7, 5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd20, 5'd9};
    cols_set = '{5'd4, 5'd1, 5'd3, 5'd1, 5'd4, 5'd0, 5'd7, 5'd2, 5'd29, 5'd14};
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      apply_settings(len_set[p], cols_set[p]);
      gaps_on = (p % 4 != 2);
      target  = useful_items + PHASE_ITEMS;
      while (useful_items < target) begin
        len  = eff_len();
        tag  = mmr_pkg::ROW_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          send_row(tag, len - 1);
        end else if (pick < 84) begin
          send_item(mmr_pkg::OP_LOAD_B, mmr_pkg::ROW_W'($urandom), mmr_pkg::IDX_W'($urandom),
                    mmr_pkg::COL_W'($urandom), pick_elem());
        end else if (pick < 94) begin
          send_item(mmr_pkg::OP_STREAM_A, tag, mmr_pkg::IDX_W'($urandom),
                    mmr_pkg::COL_W'($urandom), pick_elem());
        end else begin
          // cut short: the partial sums carry into the next row
          send_row(tag, $urandom_range(0, len - 1));
        end
      end
    end
  endtask

  initial begin
    for (int j = 0; j < NUM_COLS; j++) col_sums[j] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_store();
    test_directed();
    test_backpressure();
    test_random_phases();
    settle();
    $display("Run covered %0d accepted items (%0d effective) under %0d register settings,",
             items_accepted, useful_items, settings_applied);
    $display("closing %0d rows and checking %0d result beats.", rows_done, beats_checked);
    if (err_count == 0) begin
      $display("tb_int32_matrix_multiply_rows_unit: done, clean");
    end else begin
      $display("tb_int32_matrix_multiply_rows_unit: done, errors");
    end
    $finish;
  end

endmodule
